// ===== rtl/swcn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swcn_pkg: shared types and constants
// Word types, register indexes and arithmetic widths of the normalizer.
// ----------------------------------------------------------------------------
package swcn_pkg;

  localparam int unsigned MAX_WINDOW_DEF = 1024;
  localparam int unsigned LEN_W          = 11;
  localparam logic [LEN_W-1:0] LEN_RESET = 11'd512;

  localparam logic [0:0] REG_WINDOW_LEN  = 1'b0;
  localparam logic [0:0] REG_TMPL_FACTOR = 1'b1;
  localparam int unsigned CFG_IDX_W      = 1;

  typedef struct packed {
    logic signed [15:0] sample;
    logic signed [31:0] corr;
    logic               final_item;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] norm_corr;
    logic               flat_window;
    logic               last;
  } out_word_t;

endpackage

// ===== rtl/swcn_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swcn_ram: generic single port ram
// One write and one read per cycle at the same address, registered read data.
// ----------------------------------------------------------------------------
module swcn_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ===== rtl/swcn_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swcn_divider: shared restoring unit
// Unsigned divide (one quotient bit per cycle) or integer square root
// (one result bit per cycle) on a 96 bit radicand/dividend.
// ----------------------------------------------------------------------------
module swcn_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        sqrt_mode,
  input  logic [95:0] num,
  input  logic [63:0] den,
  output logic        done,
  output logic [95:0] quo,
  output logic [95:0] rem
);
  logic [95:0] q_r, q_nxt;
  logic [97:0] r_r, r_nxt;
  logic [95:0] n_r, n_nxt;
  logic [63:0] d_r, d_nxt;
  logic        m_r, m_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [97:0] trial;
  logic [97:0] sub;

  always_comb begin
    q_nxt = q_r; r_nxt = r_r; n_nxt = n_r; d_nxt = d_r; m_nxt = m_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r; done_nxt = 1'b0;
    trial = '0; sub = '0;
    if (start) begin
      q_nxt = '0; r_nxt = '0; n_nxt = num; d_nxt = den; m_nxt = sqrt_mode;
      cnt_nxt = sqrt_mode ? 7'd48 : 7'd96;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (m_r) begin
        // two radicand bits in, test 4q+1
        trial = {r_r[95:0], n_r[95:94]};
        sub   = {q_r[95:0], 2'b01};
        n_nxt = {n_r[93:0], 2'b00};
      end else begin
        trial = {r_r[96:0], n_r[95]};
        sub   = {34'd0, d_r};
        n_nxt = {n_r[94:0], 1'b0};
      end
      if (trial >= sub) begin
        r_nxt = trial - sub;
        q_nxt = {q_r[94:0], 1'b1};
      end else begin
        r_nxt = trial;
        q_nxt = {q_r[94:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; r_r <= r_nxt; n_r <= n_nxt; d_r <= d_nxt; m_r <= m_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;
  assign rem  = r_r[95:0];
endmodule

// ===== rtl/sliding_window_correlation_normalizer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_correlation_normalizer_unit: windowed mean/std normalizer
// Normalizes raw correlation words by the mean and spread of a sliding
// window of image samples.
// ----------------------------------------------------------------------------
// Usage:
//  in_ words (sample, corr, final_item) are taken when in_valid is high and
//  in_stall low. in_stall is high while a word is being worked on and while
//  a finished result waits on a stalled receiver.
//  A word that fills or slides a full window gives one out_ word; others
//  give none. final_item clears the window after the word is handled.
//  A word without a result passes S_RD, S_UPD and S_SQ. A result also takes
//  three divides and one square root, one bit per cycle in the single shared
//  restoring unit; a flat window skips the last divide. One word is worked
//  on at a time: the next is not taken before this one is done, nor while
//  its result waits on a stalled receiver.
//  The result sits in an output register until out_stall is low; the next
//  input word is taken in the same cycle the result leaves.
//  cfg_ writes: index 0 window_len (clears the window), 1 template sum factor.
//  cfg_ready is high only while idle. Synchronous reset: empty window,
//  window_len 512, template sum factor 0. The sample store needs no clearing.
// ----------------------------------------------------------------------------
module sliding_window_correlation_normalizer_unit #(
  parameter int unsigned MAX_WINDOW = swcn_pkg::MAX_WINDOW_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  swcn_pkg::in_word_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output swcn_pkg::out_word_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [swcn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                     cfg_wdata
);
  import swcn_pkg::*;

  localparam int unsigned AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned CW = $clog2(MAX_WINDOW + 1);
  // running sum and sum of squares sized by the window depth
  localparam int unsigned SW = 17 + AW;
  localparam int unsigned QW = 31 + AW;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_UPD, S_SQ, S_MEAN, S_VAR, S_SQRT, S_NUM, S_DIV, S_OUT
  } state_t;

  state_t state_r;
  logic [LEN_W-1:0]   len_r;
  logic signed [31:0] nsum_r;
  logic signed [SW-1:0] sum_r;
  logic [QW-1:0]      sq_r;
  logic [CW-1:0]      fill_r;
  logic [AW-1:0]      wp_r;
  in_word_t           in_r;
  logic signed [31:0] prod_r;
  logic [63:0]        d_r;
  logic signed [47:0] mean_r;
  logic [63:0]        std_r;
  logic signed [79:0] numv_r;
  out_word_t          out_r;
  logic               outv_r;

  // effective window length, clamped
  logic [CW-1:0] l_eff;
  always_comb begin
    if (len_r < 11'd2) l_eff = CW'(2);
    else if ({21'd0, len_r} > 32'(MAX_WINDOW)) l_eff = CW'(MAX_WINDOW);
    else l_eff = CW'(len_r);
  end

  logic [AW-1:0] wp_eff;
  assign wp_eff = ({{(32-AW){1'b0}}, wp_r} >= 32'(l_eff)) ? '0 : wp_r;

  logic        ram_we;
  logic [15:0] ram_rd;
  swcn_ram #(.WIDTH(16), .DEPTH(1 << AW)) u_ram (
    .clk(clk), .we(ram_we), .addr(wp_eff), .wdata(in_r.sample), .rdata(ram_rd)
  );

  logic        dv_start, dv_sqrt, dv_done;
  logic [95:0] dv_num, dv_quo, dv_rem;
  logic [63:0] dv_den;
  swcn_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .sqrt_mode(dv_sqrt),
    .num(dv_num), .den(dv_den), .done(dv_done), .quo(dv_quo), .rem(dv_rem)
  );

  logic dv_go_r;
  logic [47:0] mag_sum;
  logic [63:0] l64;
  assign l64     = 64'(l_eff);
  assign mag_sum = 48'(sum_r[SW-1] ? -64'(sum_r) : 64'(sum_r));

  logic signed [16:0] old_s;
  logic signed [31:0] old_sq, new_sq;
  logic signed [31:0] mres;
  logic signed [63:0] mprod;
  assign old_s  = {ram_rd[15], ram_rd};
  assign old_sq = 32'(old_s) * 32'(old_s);
  assign new_sq = 32'(in_r.sample) * 32'(in_r.sample);
  // the rounded mean always fits in 32 signed bits
  assign mres   = $signed(mean_r[31:0]);
  assign mprod  = nsum_r * mres;

  assign in_stall  = (state_r != S_IDLE) || (outv_r && out_stall);
  assign out_valid = outv_r;
  assign out_data  = out_r;
  assign cfg_ready = (state_r == S_IDLE);
  assign ram_we    = (state_r == S_UPD);

  always_comb begin
    dv_start = dv_go_r;
    dv_sqrt = 1'b0; dv_num = '0; dv_den = l64;
    unique case (state_r)
      S_MEAN: begin dv_num = {mag_sum, 16'd0} + 96'(l64 >> 1); dv_den = l64; end
      S_VAR:  begin dv_num = {d_r, 32'd0}; dv_den = l64 * l64; end
      S_SQRT: begin dv_sqrt = 1'b1; dv_num = dv_quo; end
      S_DIV:  begin
        dv_num = numv_r[79] ? 96'(-numv_r) : 96'(numv_r); dv_den = std_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; len_r <= LEN_RESET; nsum_r <= '0;
      sum_r <= '0; sq_r <= '0; fill_r <= '0; wp_r <= '0;
      outv_r <= 1'b0; dv_go_r <= 1'b0;
    end else begin
      dv_go_r <= 1'b0;
      if (outv_r && !out_stall && state_r != S_OUT) outv_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_WINDOW_LEN) begin
          len_r <= cfg_wdata[LEN_W-1:0];
          sum_r <= '0; sq_r <= '0; fill_r <= '0; wp_r <= '0;
        end else if (cfg_index == REG_TMPL_FACTOR) begin
          nsum_r <= cfg_wdata;
        end
      end
      unique case (state_r)
        S_IDLE: if (in_valid && !in_stall) begin
          in_r <= in_data; state_r <= S_RD;
        end
        S_RD: state_r <= S_UPD; // ram read data arrives
        S_UPD: begin
          if (fill_r >= l_eff) begin
            sum_r <= sum_r - SW'(old_s) + SW'(in_r.sample);
            prod_r <= old_sq;
          end else begin
            sum_r <= sum_r + SW'(in_r.sample);
            prod_r <= '0;
            fill_r <= fill_r + 1'b1;
          end
          wp_r <= (32'(wp_eff) + 1 >= 32'(l_eff)) ? '0 : AW'(wp_eff + 1'b1);
          state_r <= S_SQ;
        end
        S_SQ: begin
          if (fill_r == l_eff) begin
            sq_r <= sq_r - QW'(prod_r) + QW'(new_sq);
            state_r <= S_MEAN; dv_go_r <= 1'b1;
          end else begin
            if (in_r.final_item) begin
              sum_r <= '0; sq_r <= '0; fill_r <= '0; wp_r <= '0;
            end else begin
              sq_r <= sq_r - QW'(prod_r) + QW'(new_sq);
            end
            state_r <= S_IDLE;
          end
        end
        S_MEAN: begin
          if (dv_go_r) d_r <= 64'(l64 * 64'(sq_r)) - 64'(64'(sum_r) * 64'(sum_r));
          if (dv_done) begin
            mean_r <= sum_r[SW-1] ? -48'(dv_quo) : 48'(dv_quo);
            state_r <= S_VAR; dv_go_r <= 1'b1;
          end
        end
        S_VAR: if (dv_done) begin state_r <= S_SQRT; dv_go_r <= 1'b1; end
        S_SQRT: if (dv_done) begin
          std_r <= dv_quo[63:0]; state_r <= S_NUM;
        end
        S_NUM: begin
          numv_r <= 80'($signed({in_r.corr, 16'd0})) - 80'(mprod);
          if (std_r == '0) begin
            out_r.norm_corr <= '0; out_r.flat_window <= 1'b1;
            state_r <= S_OUT;
          end else begin
            out_r.flat_window <= 1'b0; state_r <= S_DIV; dv_go_r <= 1'b1;
          end
        end
        S_DIV: if (dv_done) begin
          if (numv_r[79]) begin
            out_r.norm_corr <= (dv_quo >= 96'h8000_0000) ? 32'h8000_0000 : -dv_quo[31:0];
          end else begin
            out_r.norm_corr <= (dv_quo > 96'h7FFF_FFFF) ? 32'h7FFF_FFFF : dv_quo[31:0];
          end
          state_r <= S_OUT;
        end
        S_OUT: if (!outv_r || !out_stall) begin
          out_r.last <= in_r.final_item; outv_r <= 1'b1;
          if (in_r.final_item) begin
            sum_r <= '0; sq_r <= '0; fill_r <= '0; wp_r <= '0;
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/swcn_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swcn_checker: port level checks
// Watches the top level ports for handshake and result rules.
// ----------------------------------------------------------------------------
module swcn_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input swcn_pkg::out_word_t out_data
);
  import swcn_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("out hold");
  // flat window forces zero
  a_flat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.flat_window |-> out_data.norm_corr == 32'd0) else $error("flat");
  // a word taken is worked on before the next
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall) else $error("busy");
  // reset leaves no result word pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("reset");
endmodule

bind sliding_window_correlation_normalizer_unit swcn_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

// ===== tb/sv/tb_sliding_window_correlation_normalizer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sliding_window_correlation_normalizer_unit: normalizer testbench
// Streams sample/correlation words through the block under random valid and
// stall gaps. A behavioral model of the window mean/std normalization predicts
// every result, and each result is compared field by field.
// ----------------------------------------------------------------------------
module tb_sliding_window_correlation_normalizer_unit;
  import swcn_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  out_word_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  always #2 clk = ~clk;

  sliding_window_correlation_normalizer_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  in_word_t  samples_pending[$];
  out_word_t norm_results_due[$];
  int errors = 0;
  bit calm = 1'b0;
  bit hold_sender = 1'b0;

  // window model
  logic signed [15:0] win_samples [MAX_WINDOW_DEF];
  longint win_sum, win_sumsq;
  int fill_cnt, wr_ptr;
  logic [LEN_W-1:0] win_len_reg;
  logic signed [31:0] tmpl_factor_reg;

  function automatic void clear_window();
    win_sum = 0;
    win_sumsq = 0;
    fill_cnt = 0;
    wr_ptr = 0;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // returns 1 when the word closes a window; res holds the normalized word
  function automatic bit normalize_sample(in_word_t w, output out_word_t res);
    longint l, s, old, d, lsq, ms, mm, mq, mean_q, num, mag, q;
    longint unsigned var_q, std_q;
    bit produced;
    l = (win_len_reg < 2) ? 2 : (win_len_reg > MAX_WINDOW_DEF) ? MAX_WINDOW_DEF : win_len_reg;
    s = w.sample;
    res = '0;
    if (wr_ptr >= l) wr_ptr = 0;
    if (fill_cnt >= l) begin
      old = win_samples[wr_ptr];
      win_sum -= old;
      win_sumsq -= old * old;
    end
    win_samples[wr_ptr] = w.sample;
    win_sum += s;
    win_sumsq += s * s;
    wr_ptr = (wr_ptr + 1 >= l) ? 0 : wr_ptr + 1;
    if (fill_cnt < l) fill_cnt++;
    produced = (fill_cnt == l);
    if (produced) begin
      lsq = l * l;
      d = l * win_sumsq - win_sum * win_sum;
      ms = win_sum * 65536;
      mm = (ms < 0) ? -ms : ms;
      mq = (mm + l / 2) / l;
      mean_q = (ms < 0) ? -mq : mq;
      var_q = ((d / lsq) << 32) + (((d % lsq) << 32) / lsq);
      std_q = int_sqrt(var_q);
      res.last = w.final_item;
      if (std_q == 0) begin
        res.flat_window = 1'b1;
      end else begin
        num = longint'(w.corr) * 65536 - longint'(tmpl_factor_reg) * mean_q;
        mag = (num < 0) ? -num : num;
        q = mag / longint'(std_q);
        if (num < 0) res.norm_corr = (q >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-q);
        else res.norm_corr = (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(q);
      end
    end
    if (w.final_item) clear_window();
    return produced;
  endfunction

  // driver
  always @(posedge clk) begin
    out_word_t nw;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid && normalize_sample(in_data, nw)) norm_results_due.push_back(nw);
      if (samples_pending.size() > 0 && !hold_sender && (calm || $urandom_range(99) >= 31)) begin
        in_valid <= 1'b1;
        in_data  <= samples_pending.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %0h expected %0h", what, got, want);
  endtask

  // monitor
  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      out_stall <= 1'b1;
    end else begin
      if (out_valid && !out_stall) begin
        if (norm_results_due.size() == 0) begin
          report("unexpected word", out_data.norm_corr, 32'd0);
        end else begin
          want = norm_results_due.pop_front();
          if (out_data.norm_corr !== want.norm_corr)
            report("norm_corr", out_data.norm_corr, want.norm_corr);
          if (out_data.flat_window !== want.flat_window)
            report("flat_window", 32'(out_data.flat_window), 32'(want.flat_window));
          if (out_data.last !== want.last)
            report("last", 32'(out_data.last), 32'(want.last));
        end
      end
      out_stall <= !calm && ($urandom_range(99) < 31);
    end
  end

  // watchdog on cycles with no word moving
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_sliding_window_correlation_normalizer_unit failed");
      $finish;
    end
  end

  task automatic wait_idle();
    do @(posedge clk);
    while (samples_pending.size() != 0 || in_valid || norm_results_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_WINDOW_LEN) begin
      win_len_reg = val[LEN_W-1:0];
      clear_window();
    end else begin
      tmpl_factor_reg = val;
    end
  endtask

  task automatic add_word(logic signed [15:0] s, logic signed [31:0] c, bit fin);
    in_word_t w;
    w.sample = s;
    w.corr = c;
    w.final_item = fin;
    samples_pending.push_back(w);
  endtask

  // random runs: mostly full windows, some spread styles, occasional run ends
  task automatic add_random(int n, int fin_pct);
    int style;
    logic signed [15:0] base;
    logic signed [31:0] c;
    for (int i = 0; i < n; i++) begin
      if (i % 16 == 0) begin
        style = $urandom_range(3);
        base = 16'($urandom);
      end
      c = ($urandom_range(3) == 0) ? $signed($urandom_range(200000)) - 100000 : $urandom;
      case (style)
        0, 1: add_word(16'($urandom), c, $urandom_range(99) < fin_pct);
        2: add_word(16'(base + $signed($urandom_range(6)) - 3), c,
                    $urandom_range(99) < fin_pct);
        default: add_word(base, c, $urandom_range(99) < fin_pct);
      endcase
    end
  endtask

  initial begin
    win_len_reg = LEN_RESET;
    tmpl_factor_reg = '0;
    clear_window();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: two-sample window
    write_reg(REG_WINDOW_LEN, 2);
    write_reg(REG_TMPL_FACTOR, 32'h0001_0000);
    add_word(16'sh0005, 32'sh0001_0000, 1'b1);  // run ends before the window fills
    add_word(-16'sd32768, 32'sh7FFF_FFFF, 1'b0);
    add_word(16'sh7FFF, 32'sh8000_0000, 1'b0);
    add_word(16'sh7FFF, 32'sh1234_5678, 1'b0);  // flat window
    add_word(16'sh7FFF, 32'sh7FFF_FFFF, 1'b0);
    add_word(16'sh0000, 32'sh0000_0000, 1'b0);
    add_word(16'sh0001, 32'sh7FFF_FFFF, 1'b0);  // positive saturation
    add_word(16'sh0000, 32'sh8000_0000, 1'b0);  // negative saturation
    add_word(-16'sd1, 32'shFFFF_0000, 1'b0);
    add_word(-16'sd32768, 32'sh0000_0001, 1'b1);
    add_word(16'sh1234, 32'shFFFF_FFFF, 1'b0);
    add_word(-16'sd1234, 32'sh0100_0000, 1'b1);
    add_word(16'sh0003, 32'sh0000_8000, 1'b0);
    add_word(16'sh0003, 32'sh0000_8000, 1'b0);
    add_word(16'sh0004, 32'shFFFF_8000, 1'b1);
    wait_idle();

    write_reg(REG_TMPL_FACTOR, 32'h8000_0000);
    add_random(20, 10);
    wait_idle();
    write_reg(REG_WINDOW_LEN, 0);  // below range, acts as two
    add_random(20, 10);
    wait_idle();
    write_reg(REG_WINDOW_LEN, 1);
    write_reg(REG_TMPL_FACTOR, 32'h7FFF_FFFF);
    add_random(20, 10);
    wait_idle();

    for (int k = 0; k < 4; k++) begin
      write_reg(REG_WINDOW_LEN, (k == 0) ? 3 : (k == 1) ? 5 : (k == 2) ? 9 : 31);
      write_reg(REG_TMPL_FACTOR, ($urandom_range(1)) ? $urandom : $urandom_range(0, 32'h0004_0000));
      calm = (k == 2);
      add_random(35, 3);
      if (k == 3) begin
        // hold the sender until the block has drained
        do @(posedge clk);
        while (samples_pending.size() > 30);
        hold_sender = 1'b1;
        do @(posedge clk);
        while (in_valid || norm_results_due.size() != 0);
        hold_sender = 1'b0;
      end
      wait_idle();
      calm = 1'b0;
    end

    // above range, acts as the largest window
    write_reg(REG_WINDOW_LEN, 11'h7FF);
    write_reg(REG_TMPL_FACTOR, $urandom);
    add_random(1039, 0);
    add_word(16'($urandom), $urandom, 1'b1);
    wait_idle();

    if (errors == 0)
      $display("tb_sliding_window_correlation_normalizer_unit passed");
    else
      $display("tb_sliding_window_correlation_normalizer_unit failed");
    $finish;
  end

endmodule
